// ===== rtl/rpv_pkg.sv =====
// rpv_pkg: shared types, codes and constants for the relative path validator
// used by every module of the block; no dependencies
package rpv_pkg;

  // input transaction: one path byte plus framing flags
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_path;
  } in_t;

  // result transaction: one verdict per path
  typedef struct packed {
    logic [2:0] verdict;
    logic       path_ok;
  } out_t;

  // verdict codes
  localparam logic [2:0] VERDICT_OK        = 3'd0;
  localparam logic [2:0] VERDICT_EMPTY     = 3'd1;
  localparam logic [2:0] VERDICT_UTF8      = 3'd2;
  localparam logic [2:0] VERDICT_LAYOUT    = 3'd3;
  localparam logic [2:0] VERDICT_COMPONENT = 3'd4;
  localparam logic [2:0] VERDICT_ROOTNAME  = 3'd5;

  // special characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_DOT    = 8'h2E;

  // code point limits
  localparam int         CP_W    = 21;
  localparam logic [20:0] CP_MIN2 = 21'h00080;
  localparam logic [20:0] CP_MIN3 = 21'h00800;
  localparam logic [20:0] CP_MIN4 = 21'h10000;
  localparam logic [20:0] CP_MAX  = 21'h10FFFF;
  localparam logic [20:0] SURR_LO = 21'h0D800;
  localparam logic [20:0] SURR_HI = 21'h0DFFF;

  // depth of the queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // utf-8 form of one byte
  typedef enum logic [2:0] {
    UK_ASCII,
    UK_LEAD2,
    UK_LEAD3,
    UK_LEAD4,
    UK_CONT,
    UK_BAD
  } ukind_t;

  // classified byte as handed from front to back
  typedef struct packed {
    logic       has_byte;
    logic       end_of_path;
    ukind_t     kind;
    logic [5:0] bits;
    logic       is_slash;
    logic       is_bslash;
    logic       is_nul;
    logic       is_colon;
    logic       is_dot;
  } cls_t;

endpackage

// ===== rtl/rpv_front.sv =====
// rpv_front: accepts input transactions and classifies each byte
// depends on rpv_pkg
module rpv_front (
  input  rpv_pkg::in_t  item,
  input  logic          push,
  input  logic          q_full,
  output logic          q_write,
  output rpv_pkg::cls_t q_data
);
  import rpv_pkg::*;

  logic [7:0] b;

  assign b = item.data_byte;

  // items with neither byte nor end change nothing and are dropped
  assign q_write = push && !q_full && (item.has_byte || item.end_of_path);

  // byte classification
  always_comb begin
    q_data             = '0;
    q_data.has_byte    = item.has_byte;
    q_data.end_of_path = item.end_of_path;
    q_data.is_slash    = (b == CH_SLASH);
    q_data.is_bslash   = (b == CH_BSLASH);
    q_data.is_nul      = (b == CH_NUL);
    q_data.is_colon    = (b == CH_COLON);
    q_data.is_dot      = (b == CH_DOT);
    if (b[7] == 1'b0) begin
      q_data.kind = UK_ASCII;
      q_data.bits = 6'd0;
    end else if (b[7:6] == 2'b10) begin
      q_data.kind = UK_CONT;
      q_data.bits = b[5:0];
    end else if (b[7:5] == 3'b110) begin
      q_data.kind = UK_LEAD2;
      q_data.bits = {1'b0, b[4:0]};
    end else if (b[7:4] == 4'b1110) begin
      q_data.kind = UK_LEAD3;
      q_data.bits = {2'b00, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      q_data.kind = UK_LEAD4;
      q_data.bits = {3'b000, b[2:0]};
    end else begin
      q_data.kind = UK_BAD;
      q_data.bits = 6'd0;
    end
  end

endmodule

// ===== rtl/rpv_queue.sv =====
// rpv_queue: short queue of classified bytes between front and back
// depends on rpv_pkg
module rpv_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  rpv_pkg::cls_t wr_data,
  input  logic          rd,
  output rpv_pkg::cls_t rd_data,
  output logic          valid,
  output logic          full
);
  import rpv_pkg::*;

  cls_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic [QCNT_W-1:0] count_next;

  assign valid   = (count != '0);
  assign full    = (count == QCNT_W'(QDEPTH));
  assign rd_data = mem[rd_ptr];

  always_comb begin
    count_next = count;
    if (wr && !rd) begin
      count_next = count + QCNT_W'(1);
    end else if (rd && !wr) begin
      count_next = count - QCNT_W'(1);
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (wr) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

// ===== rtl/rpv_back.sv =====
// rpv_back: tracks utf-8, layout and component state and forms the verdict
// depends on rpv_pkg
module rpv_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  rpv_pkg::cls_t q_data,
  output logic          q_read,
  input  logic          pop,
  output logic          empty,
  output rpv_pkg::out_t result
);
  import rpv_pkg::*;

  logic [1:0]      pend, pend_next;
  logic [1:0]      seq_len, seq_len_next;
  logic [CP_W-1:0] pcp, pcp_next;
  logic            uerr, uerr_next;
  logic            lerr, lerr_next;
  logic            at_start, at_start_next;
  logic [1:0]      clen, clen_next;
  logic            all_dots, all_dots_next;
  logic            first_comp, first_comp_next;
  logic [2:0]      cerr, cerr_next;
  logic            out_valid;
  out_t            out_reg;
  logic [2:0]      verdict_next;
  logic [CP_W-1:0] cp;
  logic            out_space;

  // component that is empty, "." or ".."
  function automatic logic comp_bad(input logic [1:0] len, input logic dots);
    comp_bad = (len == 2'd0) || (dots && (len <= 2'd2));
  endfunction

  assign out_space = !out_valid || pop;
  assign q_read    = q_valid && out_space;
  assign empty     = !out_valid;
  assign result    = out_reg;

  // next state for one classified byte, then the verdict on an end item
  always_comb begin
    pend_next       = pend;
    seq_len_next    = seq_len;
    pcp_next        = pcp;
    uerr_next       = uerr;
    lerr_next       = lerr;
    at_start_next   = at_start;
    clen_next       = clen;
    all_dots_next   = all_dots;
    first_comp_next = first_comp;
    cerr_next       = cerr;
    verdict_next    = VERDICT_OK;
    cp              = {pcp[CP_W-7:0], q_data.bits};

    if (q_read && q_data.has_byte) begin
      // utf-8 decoder, frozen once in error
      if (!uerr) begin
        if (pend == 2'd0) begin
          unique case (q_data.kind)
            UK_ASCII: ;
            UK_LEAD2: begin
              pcp_next     = CP_W'(q_data.bits);
              seq_len_next = 2'd1;
              pend_next    = 2'd1;
            end
            UK_LEAD3: begin
              pcp_next     = CP_W'(q_data.bits);
              seq_len_next = 2'd2;
              pend_next    = 2'd2;
            end
            UK_LEAD4: begin
              pcp_next     = CP_W'(q_data.bits);
              seq_len_next = 2'd3;
              pend_next    = 2'd3;
            end
            default: uerr_next = 1'b1;
          endcase
        end else if (q_data.kind != UK_CONT) begin
          uerr_next = 1'b1;
        end else begin
          pcp_next  = cp;
          pend_next = pend - 2'd1;
          if (pend == 2'd1) begin
            // sequence complete: overlong, surrogate and range checks
            if ((seq_len == 2'd1 && cp < CP_MIN2) ||
                (seq_len == 2'd2 && cp < CP_MIN3) ||
                (seq_len == 2'd3 && cp < CP_MIN4) ||
                cp > CP_MAX || (cp >= SURR_LO && cp <= SURR_HI)) begin
              uerr_next = 1'b1;
            end
            pcp_next     = '0;
            seq_len_next = 2'd0;
          end
        end
      end

      // layout checks
      if ((at_start && q_data.is_slash) || q_data.is_bslash || q_data.is_nul) begin
        lerr_next = 1'b1;
      end
      at_start_next = 1'b0;

      // component tracking
      if (q_data.is_slash) begin
        if (cerr == VERDICT_OK && comp_bad(clen, all_dots)) begin
          cerr_next = VERDICT_COMPONENT;
        end
        clen_next       = 2'd0;
        all_dots_next   = 1'b1;
        first_comp_next = 1'b0;
      end else begin
        if (q_data.is_colon && first_comp && cerr == VERDICT_OK) begin
          cerr_next = VERDICT_ROOTNAME;
        end
        if (!q_data.is_dot) begin
          all_dots_next = 1'b0;
        end
        if (clen != 2'd3) begin
          clen_next = clen + 2'd1;
        end
      end
    end

    // verdict in priority order, then back to the start state
    if (q_read && q_data.end_of_path) begin
      if (at_start_next) begin
        verdict_next = VERDICT_EMPTY;
      end else if (uerr_next || pend_next != 2'd0) begin
        verdict_next = VERDICT_UTF8;
      end else if (lerr_next) begin
        verdict_next = VERDICT_LAYOUT;
      end else if (cerr_next == VERDICT_OK && comp_bad(clen_next, all_dots_next)) begin
        verdict_next = VERDICT_COMPONENT;
      end else begin
        verdict_next = cerr_next;
      end
      pend_next       = 2'd0;
      seq_len_next    = 2'd0;
      pcp_next        = '0;
      uerr_next       = 1'b0;
      lerr_next       = 1'b0;
      at_start_next   = 1'b1;
      clen_next       = 2'd0;
      all_dots_next   = 1'b1;
      first_comp_next = 1'b1;
      cerr_next       = VERDICT_OK;
    end
  end

  // path state
  always_ff @(posedge clk) begin
    if (rst) begin
      pend       <= 2'd0;
      seq_len    <= 2'd0;
      pcp        <= '0;
      uerr       <= 1'b0;
      lerr       <= 1'b0;
      at_start   <= 1'b1;
      clen       <= 2'd0;
      all_dots   <= 1'b1;
      first_comp <= 1'b1;
      cerr       <= VERDICT_OK;
    end else begin
      pend       <= pend_next;
      seq_len    <= seq_len_next;
      pcp        <= pcp_next;
      uerr       <= uerr_next;
      lerr       <= lerr_next;
      at_start   <= at_start_next;
      clen       <= clen_next;
      all_dots   <= all_dots_next;
      first_comp <= first_comp_next;
      cerr       <= cerr_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_read && q_data.end_of_path) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_read && q_data.end_of_path) begin
      out_reg.verdict <= verdict_next;
      out_reg.path_ok <= (verdict_next == VERDICT_OK);
    end
  end

endmodule

// ===== rtl/relative_path_validator.sv =====
// relative_path_validator: top level, byte classifier, queue and checker back end
// depends on rpv_pkg, rpv_front, rpv_queue, rpv_back
//
// Checks one relative path per run of input transactions, one byte per
// transaction, and gives one verdict transaction on the item that carries
// end_of_path: 0 ok, 1 empty, 2 bad utf-8, 3 leading slash, backslash or
// nul, 4 empty, "." or ".." component, 5 colon in the first component.
// The block takes one transaction every clock cycle while full is low;
// the front classifies each byte and writes it to a four-entry queue, and
// the back end updates the path state for one queued byte per cycle while
// the result register has space, that single state update setting the
// rate. The verdict is registered when the back end reads the end item
// from the queue. The input side stalls (full) only when the result
// register is held by a missing pop long enough to fill the queue.
module relative_path_validator (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  rpv_pkg::in_t  item,
  output logic          empty,
  input  logic          pop,
  output rpv_pkg::out_t result
);
  import rpv_pkg::*;

  logic q_write;
  logic q_read;
  logic q_valid;
  cls_t q_wdata;
  cls_t q_rdata;

  // byte classification
  rpv_front u_front (
    .item    (item),
    .push    (push),
    .q_full  (full),
    .q_write (q_write),
    .q_data  (q_wdata)
  );

  // decoupling queue
  rpv_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_write),
    .wr_data (q_wdata),
    .rd      (q_read),
    .rd_data (q_rdata),
    .valid   (q_valid),
    .full    (full)
  );

  // path state and verdict
  rpv_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_rdata),
    .q_read  (q_read),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule

// ===== rtl/rpv_checker.sv =====
// rpv_checker: port-level assertions for relative_path_validator
// depends on rpv_pkg; bound to the top level below
module rpv_checker (
  input logic          clk,
  input logic          rst,
  input logic          push,
  input logic          full,
  input rpv_pkg::in_t  item,
  input logic          empty,
  input logic          pop,
  input rpv_pkg::out_t result
);
  import rpv_pkg::*;

  // reset leaves both sides with nothing held
  a_reset_clear: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not clear after reset");

  // an accepted transaction carries known bits
  a_item_known: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |-> !$isunknown(item))
    else $error("unknown bits in accepted transaction");

  // path_ok agrees with the verdict code
  a_ok_match: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.path_ok == (result.verdict == VERDICT_OK)))
    else $error("path_ok disagrees with verdict");

  // verdict is a defined code
  a_verdict_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.verdict <= VERDICT_ROOTNAME))
    else $error("undefined verdict code");

  // a waiting result stays put until popped
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("result changed while waiting");

endmodule

bind relative_path_validator rpv_checker u_rpv_checker (
  .clk    (clk),
  .rst    (rst),
  .push   (push),
  .full   (full),
  .item   (item),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);
